FILE: rtl/anchored_regex_prefix_matcher_defines.svh
// ----------------------------------------------------------------------------
// anchored regex prefix matcher assertion macros
// shared property forms on clk with asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef ANCHORED_REGEX_PREFIX_MATCHER_DEFINES_SVH
`define ANCHORED_REGEX_PREFIX_MATCHER_DEFINES_SVH

// same-cycle implication
`define ARPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/arpm_pkg.sv
// ----------------------------------------------------------------------------
// arpm_pkg
// types, codes and constants shared by the prefix matcher modules
// ----------------------------------------------------------------------------
`default_nettype none

package arpm_pkg;

    localparam int PATTERN_CHARS = 16;
    localparam int LENGTH_BITS   = 16;
    localparam int POS_BITS      = 5;
    localparam int GUARD_LIMIT   = PATTERN_CHARS + 2;

    localparam logic [7:0] CH_ANY  = 8'h2E;
    localparam logic [7:0] CH_ESC  = 8'h5C;
    localparam logic [7:0] CH_OPT  = 8'h3F;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_END  = 8'h00;

    typedef enum logic [1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP
    } state_t;

    typedef enum logic [1:0] {
        OC_PENDING,
        OC_MATCH,
        OC_NOMATCH,
        OC_BAD
    } outcome_t;

    typedef struct packed {
        logic load;
        logic check;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/anchored_regex_prefix_matcher.sv
// ----------------------------------------------------------------------------
// anchored_regex_prefix_matcher
// matches a configured pattern of up to 16 characters against the start of
// a subject arriving one character per beat
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes pattern_chars_low (0), pattern_chars_high (1) and
//   pattern_length (2) while the block is idle; cfg_ready is always high
//   s_* carries one subject character per beat, s_tlast marks end of subject
//   m_* returns one result beat per input beat: tuser holds the flags,
//   tdata the consumed length
// timing:
//   m_tvalid rises once the matcher has run the check state (ST_CHECK) and,
//   unless the check decides, the step state (ST_STEP) as it walks across
//   the pattern for the given character
//   a new beat is taken only once the current one has its result
//   while a result waits, a new beat is accepted only in a cycle where
//   m_tready takes that result
// reset:
//   clears pattern registers, position, count, settled flag and step guard; no result pending
// stall:
//   a held result blocks further input until m_tready takes it
// ----------------------------------------------------------------------------
`default_nettype none

module anchored_regex_prefix_matcher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // subject_char
    input  wire logic        s_tlast,   // end_of_subject
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // match_length
    output logic [2:0]       m_tuser    // pattern_error, matched, decided
);
    import arpm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    arpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    arpm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .out_length (m_tdata),
        .out_flags  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/arpm_datapath.sv
// ----------------------------------------------------------------------------
// arpm_datapath
// pattern registers, match position, consumed count and one matcher step
// per cycle under command of the controller
// ----------------------------------------------------------------------------
`default_nettype none

module arpm_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire arpm_pkg::cmd_t       cmd,
    output arpm_pkg::status_t         status,
    input  wire logic                 cfg_write,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [63:0]          cfg_data,
    input  wire logic [7:0]           in_char,
    input  wire logic                 in_last,
    output logic [15:0]               out_length,
    output logic [2:0]                out_flags
);
    import arpm_pkg::*;

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

    logic [63:0]            pat_low_reg;
    logic [63:0]            pat_high_reg;
    logic [4:0]             pat_len_reg;
    logic [7:0]             char_reg;
    logic                   last_reg;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next, count_take;
    logic                   settled_reg, settled_next;
    logic [4:0]             guard_reg, guard_next;
    logic [15:0]            length_reg;
    logic [2:0]             flags_reg;

    logic [127:0]           pat_word;
    logic [5:0]             idx;
    logic [7:0]             p0, p, n, n2, pr;
    logic                   take, done;
    outcome_t               outcome;

    function automatic logic [7:0] pat_at(input logic [127:0] word, input logic [4:0] len,
                                          input logic [5:0] pos);
        logic [7:0] ch;
        ch = word[{pos[3:0], 3'b000} +: 8];
        if (pos >= 6'(PATTERN_CHARS) || {1'b0, len} <= pos)
        begin
            ch = CH_END;
        end
        return ch;
    endfunction

    function automatic logic is_quant(input logic [7:0] ch);
        return ch == CH_OPT || ch == CH_STAR || ch == CH_PLUS;
    endfunction

    assign pat_word = {pat_high_reg, pat_low_reg};
    assign idx      = {1'b0, pos_reg};
    assign p0       = pat_at(pat_word, pat_len_reg, 6'd0);
    assign p        = pat_at(pat_word, pat_len_reg, idx);
    assign n        = pat_at(pat_word, pat_len_reg, idx + 6'd1);
    assign n2       = pat_at(pat_word, pat_len_reg, idx + 6'd2);
    assign pr       = (pos_reg != '0) ? pat_at(pat_word, pat_len_reg, idx - 6'd1) : CH_END;

    assign count_take = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        pos_next     = pos_reg;
        count_next   = count_reg;
        settled_next = settled_reg;
        guard_next   = guard_reg;
        take         = 1'b0;
        done         = 1'b0;
        outcome      = OC_PENDING;

        if (cmd.check)
        begin
            guard_next = '0;
            if (settled_reg)
            begin
                done = 1'b1;
            end
            else if (is_quant(p0))
            begin
                done    = 1'b1;
                outcome = OC_BAD;
            end
            else if (p == CH_END)
            begin
                done    = 1'b1;
                outcome = OC_MATCH;
            end
            else if (last_reg)
            begin
                done    = 1'b1;
                outcome = OC_NOMATCH;
            end
        end
        else if (cmd.step)
        begin
            guard_next = guard_reg + 1'b1;
            if (guard_reg == 5'(GUARD_LIMIT))
            begin
                done    = 1'b1;
                outcome = OC_NOMATCH;
            end
            else if (p == CH_END)
            begin
                done    = 1'b1;
                outcome = OC_MATCH;
            end
            else if (p == CH_ESC)
            begin
                done = 1'b1;
                if (n == CH_END)
                begin
                    outcome = OC_BAD;
                end
                else if (n != char_reg)
                begin
                    outcome = OC_NOMATCH;
                end
                else
                begin
                    pos_next = pos_reg + 5'd2;
                    take     = 1'b1;
                    outcome  = (n2 == CH_END) ? OC_MATCH : OC_PENDING;
                end
            end
            else if (p == CH_ANY || p == char_reg)
            begin
                done     = 1'b1;
                pos_next = pos_reg + 5'd1;
                take     = 1'b1;
                outcome  = (n == CH_END) ? OC_MATCH : OC_PENDING;
            end
            else if ((p == CH_PLUS || p == CH_STAR) && pos_reg != '0
                     && (pr == CH_ANY || pr == char_reg))
            begin
                done = 1'b1;
                take = 1'b1;
            end
            else if (is_quant(p))
            begin
                pos_next = pos_reg + 5'd1;
            end
            else if (n == CH_OPT || n == CH_STAR)
            begin
                pos_next = pos_reg + 5'd2;
            end
            else
            begin
                done     = 1'b1;
                pos_next = pos_reg + 5'd1;
                outcome  = OC_NOMATCH;
            end
        end

        if (take)
        begin
            count_next = count_take;
        end

        if (done)
        begin
            if (outcome != OC_PENDING)
            begin
                settled_next = 1'b1;
            end
            if (last_reg)
            begin
                pos_next     = '0;
                count_next   = '0;
                settled_next = 1'b0;
            end
        end
    end

    assign status.done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            pos_reg      <= '0;
            count_reg    <= '0;
            settled_reg  <= 1'b0;
            guard_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PAT_LOW:  pat_low_reg  <= cfg_data;
                    REG_PAT_HIGH: pat_high_reg <= cfg_data;
                    REG_PAT_LEN:  pat_len_reg  <= cfg_data[4:0];
                    default:      ;
                endcase
            end
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            settled_reg <= settled_next;
            guard_reg   <= guard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
        if (done)
        begin
            length_reg <= 16'(take ? count_take : count_reg);
            flags_reg  <= {outcome == OC_BAD, outcome == OC_MATCH, outcome != OC_PENDING};
        end
    end

    assign out_length = length_reg;
    assign out_flags  = flags_reg;

endmodule

`default_nettype wire

FILE: rtl/arpm_ctrl.sv
// ----------------------------------------------------------------------------
// arpm_ctrl
// sequencer for the prefix matcher: input handshake, check and step phases,
// output valid
// ----------------------------------------------------------------------------
`default_nettype none
`include "anchored_regex_prefix_matcher_defines.svh"

module arpm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output arpm_pkg::cmd_t            cmd,
    input  wire arpm_pkg::status_t    status
);
    import arpm_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        s_tready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = !out_valid_reg || m_tready;
                if (s_tvalid && s_tready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (status.done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    // accepted beat always goes to the check phase
    `ARPM_ASSERT_NEXT(a_accept_to_check, s_tvalid && s_tready, state_reg == ST_CHECK,
        "accepted beat did not start the check phase")
    // output register is empty while an item is in work
    `ARPM_ASSERT_NOW(a_out_free_busy, state_reg != ST_IDLE, !out_valid_reg,
        "result pending while an item is in work")
    // a finished item leaves a result waiting
    `ARPM_ASSERT_NEXT(a_done_gives_beat, (cmd.check || cmd.step) && status.done,
        m_tvalid && state_reg == ST_IDLE, "finished item produced no result beat")

endmodule

`default_nettype wire
